@@ sv/swm_pkg.sv @@
// ---------------------------------------------------------------------------
// swm_pkg: shared types for the sliding window median block
// Holds the cell command format and the sequencer state encoding.
// ---------------------------------------------------------------------------
package swm_pkg;

    localparam int unsigned SCORE_W  = 32;
    localparam int unsigned VALUE_W  = 31;
    localparam int unsigned MEDIAN_W = 32;
    localparam int unsigned COUNT_W  = 6;
    localparam int unsigned WSIZE_W  = 6;
    localparam int unsigned WSIZE_RESET = 32;

    typedef logic [VALUE_W-1:0] swm_value_t;

    // Operation that every cell of the sorted chain performs.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_DELETE,
        CELL_INSERT,
        CELL_CLEAR
    } swm_cell_op_t;

    typedef struct packed {
        swm_cell_op_t op;
        swm_value_t   value;
    } swm_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEL,
        ST_INS,
        ST_MED,
        ST_OUT
    } swm_state_t;

endpackage

@@ sv/swm_ram.sv @@
// ---------------------------------------------------------------------------
// swm_ram: generic single write port RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module swm_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/swm_cell.sv @@
// ---------------------------------------------------------------------------
// swm_cell: one cell of the sorted score chain
// Holds one score and its ring slot tag; shifts toward a neighbor on
// delete and insert so the chain stays sorted by (score, slot).
// ---------------------------------------------------------------------------
module swm_cell #(
    parameter int unsigned TAG_W = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swm_pkg::swm_cmd_t   cmd,
    input  logic [TAG_W-1:0]    cmd_tag,
    input  logic                left_lt,
    input  logic                left_valid,
    input  swm_pkg::swm_value_t left_value,
    input  logic [TAG_W-1:0]    left_tag,
    input  logic                right_valid,
    input  swm_pkg::swm_value_t right_value,
    input  logic [TAG_W-1:0]    right_tag,
    output logic                valid,
    output swm_pkg::swm_value_t value,
    output logic [TAG_W-1:0]    tag,
    output logic                lt
);

    logic                valid_reg;
    logic                valid_next;
    swm_pkg::swm_value_t value_reg;
    swm_pkg::swm_value_t value_next;
    logic [TAG_W-1:0]    tag_reg;
    logic [TAG_W-1:0]    tag_next;

    // The key is the score with the slot tag as tie breaker, so keys are unique.
    assign lt = valid_reg && ({value_reg, tag_reg} < {cmd.value, cmd_tag});

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        tag_next   = tag_reg;
        case (cmd.op)
            swm_pkg::CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            swm_pkg::CELL_DELETE:
            begin
                if (!lt)
                begin
                    valid_next = right_valid;
                    value_next = right_value;
                    tag_next   = right_tag;
                end
            end
            swm_pkg::CELL_INSERT:
            begin
                if (!lt)
                begin
                    if (left_lt)
                    begin
                        valid_next = 1'b1;
                        value_next = cmd.value;
                        tag_next   = cmd_tag;
                    end
                    else
                    begin
                        valid_next = left_valid;
                        value_next = left_value;
                        tag_next   = left_tag;
                    end
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        tag_reg   <= tag_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign tag   = tag_reg;

endmodule

@@ sv/sliding_window_median.sv @@
// ---------------------------------------------------------------------------
// sliding_window_median: running median over a window of positive scores
// Keeps the most recent positive scores sorted in a chain of cells and
// answers every beat with the median of the scores held.
// ---------------------------------------------------------------------------
// Usage
// The input channel (s_*) carries one signed Q16.16 score per beat. A score
// above zero enters the window, replacing the oldest one once the window is
// full; a score of zero or below is dropped and leaves the window as it was.
// Every input beat produces exactly one output beat (m_*) with the median in
// Q15.17 (the sum of the two middle scores for an even count, twice the
// middle score for an odd count, zero when empty), the number of scores
// held, and in m_tuser a flag telling whether the score was stored.
// The block works on one beat at a time. A stored score passes through a
// delete pass and an insert pass of the cell chain, then a median pick and
// an output step; a dropped score skips both passes. The next beat is taken
// only once the output step is done.
// A result that the receiver stalls stays in the output register; the
// sequencer may take one more beat meanwhile and then waits in its last
// step until the output register is free again.
// Reset empties the window and sets window_size to 32. Writing window_size
// over the APB port also empties the window; write it only while idle.
// ---------------------------------------------------------------------------
module sliding_window_median #(
    parameter int unsigned MAX_WINDOW = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input beat fields: [31:0] score
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Output beat fields: [31:0] median_value, [37:32] held_count, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // Output user field: [0] accepted
    output logic [0:0]  m_tuser,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned TAG_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned CAP_W  = $clog2(MAX_WINDOW + 1);
    localparam int unsigned CMP_W  = (CAP_W > swm_pkg::WSIZE_W) ? CAP_W : swm_pkg::WSIZE_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [swm_pkg::WSIZE_W-1:0] window_size_reg;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? 32'(window_size_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swm_pkg::WSIZE_W'(swm_pkg::WSIZE_RESET);
        end
        else if (cfg_write)
        begin
            window_size_reg <= pwdata[swm_pkg::WSIZE_W-1:0];
        end
    end

    // Effective capacity: window_size clamped into 1 .. MAX_WINDOW.
    logic [CMP_W-1:0] wsize_ext;
    logic [CAP_W-1:0] cap;

    assign wsize_ext = CMP_W'(window_size_reg);

    always_comb
    begin
        if (wsize_ext == '0)
        begin
            cap = CAP_W'(1);
        end
        else if (wsize_ext > CMP_W'(MAX_WINDOW))
        begin
            cap = CAP_W'(MAX_WINDOW);
        end
        else
        begin
            cap = CAP_W'(wsize_ext);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    swm_pkg::swm_state_t state_reg;
    swm_pkg::swm_state_t state_next;

    logic                take;
    logic                in_fire;
    logic                out_free;
    logic                evict;

    swm_pkg::swm_value_t score_reg;
    logic                take_reg;
    logic [TAG_W-1:0]    write_slot_reg;
    logic [TAG_W-1:0]    write_slot_next;
    logic [CAP_W-1:0]    fill_reg;
    logic [CAP_W-1:0]    fill_next;
    logic [CAP_W-1:0]    slot_plus;

    swm_pkg::swm_cmd_t   cell_cmd;
    logic [TAG_W-1:0]    cell_cmd_tag;
    logic                ram_we;
    swm_pkg::swm_value_t ram_rdata;
    logic                slot_update;
    logic                med_load;
    logic                out_load;

    // A score is kept only if it is strictly positive.
    assign take     = !s_tdata[31] && (s_tdata != 32'd0);
    assign s_tready = (state_reg == swm_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;
    assign evict    = (fill_reg == cap);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = take ? swm_pkg::ST_DEL : swm_pkg::ST_MED;
                end
            end
            swm_pkg::ST_DEL:
            begin
                state_next = swm_pkg::ST_INS;
            end
            swm_pkg::ST_INS:
            begin
                state_next = swm_pkg::ST_MED;
            end
            swm_pkg::ST_MED:
            begin
                state_next = swm_pkg::ST_OUT;
            end
            swm_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = swm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cell_cmd.op    = swm_pkg::CELL_HOLD;
        cell_cmd.value = score_reg;
        cell_cmd_tag   = write_slot_reg;
        ram_we         = 1'b0;
        slot_update    = 1'b0;
        med_load       = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            swm_pkg::ST_IDLE:
            begin
                if (cfg_write)
                begin
                    cell_cmd.op = swm_pkg::CELL_CLEAR;
                end
            end
            swm_pkg::ST_DEL:
            begin
                // The ring entry read last cycle is the score that leaves.
                ram_we         = 1'b1;
                cell_cmd.value = ram_rdata;
                if (evict)
                begin
                    cell_cmd.op = swm_pkg::CELL_DELETE;
                end
            end
            swm_pkg::ST_INS:
            begin
                cell_cmd.op = swm_pkg::CELL_INSERT;
                slot_update = 1'b1;
            end
            swm_pkg::ST_MED:
            begin
                med_load = 1'b1;
            end
            swm_pkg::ST_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
                cell_cmd.op = swm_pkg::CELL_HOLD;
            end
        endcase
    end

    assign slot_plus = CAP_W'(write_slot_reg) + CAP_W'(1);

    always_comb
    begin
        write_slot_next = write_slot_reg;
        fill_next       = fill_reg;
        if (cfg_write)
        begin
            write_slot_next = '0;
            fill_next       = '0;
        end
        else if (slot_update)
        begin
            write_slot_next = (slot_plus >= cap) ? '0 : TAG_W'(slot_plus);
            if (fill_reg < cap)
            begin
                fill_next = fill_reg + CAP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= swm_pkg::ST_IDLE;
            write_slot_reg <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            fill_reg       <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            score_reg <= s_tdata[swm_pkg::VALUE_W-1:0];
            take_reg  <= take;
        end
    end

    // ------------------------------------------------------------------
    // Ring of scores in arrival order; tells which score leaves the window.
    // ------------------------------------------------------------------
    swm_ram #(
        .WIDTH (swm_pkg::VALUE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_slot_reg),
        .wdata (score_reg),
        .raddr (write_slot_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sorted chain of cells, lowest score in cell 0.
    // ------------------------------------------------------------------
    logic                cell_valid [MAX_WINDOW];
    swm_pkg::swm_value_t cell_value [MAX_WINDOW];
    logic [TAG_W-1:0]    cell_tag   [MAX_WINDOW];
    logic                cell_lt    [MAX_WINDOW];

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic                l_lt;
        logic                l_valid;
        swm_pkg::swm_value_t l_value;
        logic [TAG_W-1:0]    l_tag;
        logic                r_valid;
        swm_pkg::swm_value_t r_value;
        logic [TAG_W-1:0]    r_tag;

        if (i == 0)
        begin : g_first
            // Nothing lies left of cell 0, so a new score may always land here.
            assign l_lt    = 1'b1;
            assign l_valid = 1'b0;
            assign l_value = '0;
            assign l_tag   = '0;
        end
        else
        begin : g_mid
            assign l_lt    = cell_lt[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_value = cell_value[i-1];
            assign l_tag   = cell_tag[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign r_valid = 1'b0;
            assign r_value = '0;
            assign r_tag   = '0;
        end
        else
        begin : g_inner
            assign r_valid = cell_valid[i+1];
            assign r_value = cell_value[i+1];
            assign r_tag   = cell_tag[i+1];
        end

        swm_cell #(
            .TAG_W (TAG_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cell_cmd),
            .cmd_tag     (cell_cmd_tag),
            .left_lt     (l_lt),
            .left_valid  (l_valid),
            .left_value  (l_value),
            .left_tag    (l_tag),
            .right_valid (r_valid),
            .right_value (r_value),
            .right_tag   (r_tag),
            .valid       (cell_valid[i]),
            .value       (cell_value[i]),
            .tag         (cell_tag[i]),
            .lt          (cell_lt[i])
        );
    end

    // ------------------------------------------------------------------
    // Median pick. The lower and upper middle positions coincide for an odd
    // count, so their sum is always the Q15.17 median. An empty window
    // selects no valid cell and yields zero.
    // ------------------------------------------------------------------
    logic [CAP_W-1:0]    lo_idx;
    logic [CAP_W-1:0]    hi_idx;
    swm_pkg::swm_value_t lo_pick;
    swm_pkg::swm_value_t hi_pick;
    swm_pkg::swm_value_t lo_sel_reg;
    swm_pkg::swm_value_t hi_sel_reg;

    assign hi_idx = fill_reg >> 1;
    assign lo_idx = (fill_reg == '0) ? '0 : ((fill_reg - CAP_W'(1)) >> 1);

    always_comb
    begin
        lo_pick = '0;
        hi_pick = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (cell_valid[i] && (CAP_W'(i) == lo_idx))
            begin
                lo_pick = lo_pick | cell_value[i];
            end
            if (cell_valid[i] && (CAP_W'(i) == hi_idx))
            begin
                hi_pick = hi_pick | cell_value[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (med_load)
        begin
            lo_sel_reg <= lo_pick;
            hi_sel_reg <= hi_pick;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                          out_valid_reg;
    logic [swm_pkg::MEDIAN_W-1:0]  median_reg;
    logic [swm_pkg::COUNT_W-1:0]   held_reg;
    logic                          acc_reg;
    logic [swm_pkg::MEDIAN_W-1:0]  median_sum;

    assign median_sum = swm_pkg::MEDIAN_W'(lo_sel_reg) + swm_pkg::MEDIAN_W'(hi_sel_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            median_reg <= median_sum;
            held_reg   <= swm_pkg::COUNT_W'(fill_reg);
            acc_reg    <= take_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, held_reg, median_reg};
    assign m_tuser  = acc_reg;

endmodule

@@ sv/swm_checker.sv @@
// ---------------------------------------------------------------------------
// swm_checker: port level checks for the sliding window median block
// Watches the stream ports and is bound to every instance of the top level.
// ---------------------------------------------------------------------------
module swm_checker #(
    parameter int unsigned MAX_WINDOW = 32
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result must hold still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

    // The block works on one beat at a time, so it is busy right after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous beat in flight");

    // A stored score means the window cannot be empty.
    a_stored_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[37:32] != 6'd0)
        else $error("score stored but held count is zero");

    // An empty window reports a zero median.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[37:32] == 6'd0) |-> m_tdata[31:0] == 32'd0)
        else $error("empty window with nonzero median");

    // The held count never exceeds MAX_WINDOW.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_tdata[37:32]) <= 32'(MAX_WINDOW))
        else $error("held count above window capacity");

endmodule

bind sliding_window_median swm_checker #(
    .MAX_WINDOW (MAX_WINDOW)
) u_swm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
